// ===== rtl/core/pfa_pkg.sv =====
// Shared types and constants for the prime field ALU.
// Used by the interfaces, controller, datapath and top level; no dependencies.
`default_nettype none

package pfa_pkg;

  // Operand width and step counter width
  localparam int W  = 32;
  localparam int CW = $clog2(W);

  // Modulus after reset
  localparam logic [W-1:0] MOD_RESET = W'(64'hFFFF_FFFB);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4,
    OP_INV = 3'd5
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RA,
    S_RA_RUN,
    S_RA_SET,
    S_RB,
    S_RB_RUN,
    S_RB_SET,
    S_DISP,
    S_MUL_RUN,
    S_MUL_SET,
    S_EDIV,
    S_EDIV_RUN,
    S_EMUL,
    S_EMUL_RUN,
    S_EUPD,
    S_ECHK,
    S_DONE
  } state_e;

  // Datapath commands, one per cycle
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DIV_A,
    CMD_DIV_B,
    CMD_DIV_STEP,
    CMD_SET_A,
    CMD_SET_B,
    CMD_ALU,
    CMD_MUL_AB,
    CMD_MUL_STEP,
    CMD_SET_MUL,
    CMD_EINIT,
    CMD_EDIV,
    CMD_EMUL,
    CMD_EUPD,
    CMD_MUL_AT,
    CMD_SET_INV,
    CMD_FLAG,
    CMD_PUSH
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       step_last;
    logic       x_zero;
    logic       r1_zero;
    logic       r0_one;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/pfa_in_if.sv =====
// Input channel of the prime field ALU: opcode and two operands.
// Depends on pfa_pkg for the operand width.
`default_nettype none

interface pfa_in_if;
  logic                  valid;
  logic                  ready;
  logic [2:0]            op;
  logic [pfa_pkg::W-1:0] operand_a;
  logic [pfa_pkg::W-1:0] operand_b;

  modport source (output valid, output op, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input op, input operand_a, input operand_b, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pfa_out_if.sv =====
// Output channel of the prime field ALU: result and zero divisor flag.
// Depends on pfa_pkg for the operand width.
`default_nettype none

interface pfa_out_if;
  logic                  valid;
  logic                  ready;
  logic [pfa_pkg::W-1:0] result;
  logic                  zero_divisor;

  modport source (output valid, output result, output zero_divisor, input ready);
  modport sink   (input valid, input result, input zero_divisor, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pfa_ctrl.sv =====
// Sequencer for the prime field ALU: drives datapath commands per cycle.
// Depends on pfa_pkg for state, command and status types.
`default_nettype none

module pfa_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  input  pfa_pkg::dp_status_t  status_i,
  output pfa_pkg::dp_cmd_t     cmd_o
);

  pfa_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            can_push;

  assign can_push = !out_valid_q || out_ready_i;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfa_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfa_pkg::S_IDLE:     if (in_valid_i) state_d = pfa_pkg::S_RA;
      pfa_pkg::S_RA:       state_d = pfa_pkg::S_RA_RUN;
      pfa_pkg::S_RA_RUN:   if (status_i.step_last) state_d = pfa_pkg::S_RA_SET;
      pfa_pkg::S_RA_SET:   state_d = pfa_pkg::S_RB;
      pfa_pkg::S_RB:       state_d = pfa_pkg::S_RB_RUN;
      pfa_pkg::S_RB_RUN:   if (status_i.step_last) state_d = pfa_pkg::S_RB_SET;
      pfa_pkg::S_RB_SET:   state_d = pfa_pkg::S_DISP;
      pfa_pkg::S_DISP: begin
        case (pfa_pkg::op_e'(status_i.op))
          pfa_pkg::OP_MUL: state_d = pfa_pkg::S_MUL_RUN;
          pfa_pkg::OP_DIV,
          pfa_pkg::OP_INV: state_d = status_i.x_zero ? pfa_pkg::S_DONE : pfa_pkg::S_EDIV;
          default:         state_d = pfa_pkg::S_DONE;
        endcase
      end
      pfa_pkg::S_MUL_RUN:  if (status_i.step_last) state_d = pfa_pkg::S_MUL_SET;
      pfa_pkg::S_MUL_SET:  state_d = pfa_pkg::S_DONE;
      pfa_pkg::S_EDIV:     state_d = pfa_pkg::S_EDIV_RUN;
      pfa_pkg::S_EDIV_RUN: if (status_i.step_last) state_d = pfa_pkg::S_EMUL;
      pfa_pkg::S_EMUL:     state_d = pfa_pkg::S_EMUL_RUN;
      pfa_pkg::S_EMUL_RUN: if (status_i.step_last) state_d = pfa_pkg::S_EUPD;
      pfa_pkg::S_EUPD:     state_d = pfa_pkg::S_ECHK;
      pfa_pkg::S_ECHK: begin
        if (!status_i.r1_zero) begin
          state_d = pfa_pkg::S_EDIV;
        end else if (status_i.r0_one &&
                     pfa_pkg::op_e'(status_i.op) == pfa_pkg::OP_DIV) begin
          state_d = pfa_pkg::S_MUL_RUN;
        end else begin
          state_d = pfa_pkg::S_DONE;
        end
      end
      pfa_pkg::S_DONE:     if (can_push) state_d = pfa_pkg::S_IDLE;
      default:             state_d = pfa_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd_o.cmd   = pfa_pkg::CMD_NONE;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      pfa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.cmd = pfa_pkg::CMD_LOAD;
      end
      pfa_pkg::S_RA:       cmd_o.cmd = pfa_pkg::CMD_DIV_A;
      pfa_pkg::S_RA_RUN,
      pfa_pkg::S_RB_RUN,
      pfa_pkg::S_EDIV_RUN: cmd_o.cmd = pfa_pkg::CMD_DIV_STEP;
      pfa_pkg::S_RA_SET:   cmd_o.cmd = pfa_pkg::CMD_SET_A;
      pfa_pkg::S_RB:       cmd_o.cmd = pfa_pkg::CMD_DIV_B;
      pfa_pkg::S_RB_SET:   cmd_o.cmd = pfa_pkg::CMD_SET_B;
      pfa_pkg::S_DISP: begin
        case (pfa_pkg::op_e'(status_i.op))
          pfa_pkg::OP_MUL: cmd_o.cmd = pfa_pkg::CMD_MUL_AB;
          pfa_pkg::OP_DIV,
          pfa_pkg::OP_INV: cmd_o.cmd = status_i.x_zero ? pfa_pkg::CMD_FLAG
                                                       : pfa_pkg::CMD_EINIT;
          default:         cmd_o.cmd = pfa_pkg::CMD_ALU;
        endcase
      end
      pfa_pkg::S_MUL_RUN,
      pfa_pkg::S_EMUL_RUN: cmd_o.cmd = pfa_pkg::CMD_MUL_STEP;
      pfa_pkg::S_MUL_SET:  cmd_o.cmd = pfa_pkg::CMD_SET_MUL;
      pfa_pkg::S_EDIV:     cmd_o.cmd = pfa_pkg::CMD_EDIV;
      pfa_pkg::S_EMUL:     cmd_o.cmd = pfa_pkg::CMD_EMUL;
      pfa_pkg::S_EUPD:     cmd_o.cmd = pfa_pkg::CMD_EUPD;
      pfa_pkg::S_ECHK: begin
        if (status_i.r1_zero) begin
          if (!status_i.r0_one) begin
            cmd_o.cmd = pfa_pkg::CMD_FLAG;
          end else if (pfa_pkg::op_e'(status_i.op) == pfa_pkg::OP_DIV) begin
            cmd_o.cmd = pfa_pkg::CMD_MUL_AT;
          end else begin
            cmd_o.cmd = pfa_pkg::CMD_SET_INV;
          end
        end
      end
      pfa_pkg::S_DONE: begin
        if (can_push) begin
          cmd_o.cmd   = pfa_pkg::CMD_PUSH;
          out_valid_d = 1'b1;
        end
      end
      default: cmd_o.cmd = pfa_pkg::CMD_NONE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/pfa_dp.sv =====
// Datapath of the prime field ALU: shift-subtract divider, double-and-add
// modular multiplier, Euclid registers and output register. Uses pfa_pkg.
`default_nettype none

module pfa_dp (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  pfa_pkg::dp_cmd_t     cmd_i,
  input  wire [2:0]            op_i,
  input  wire [pfa_pkg::W-1:0] a_i,
  input  wire [pfa_pkg::W-1:0] b_i,
  input  wire [pfa_pkg::W-1:0] modulus_i,
  output pfa_pkg::dp_status_t  status_o,
  output logic [pfa_pkg::W-1:0] result_o,
  output logic                 zero_divisor_o
);

  localparam int W  = pfa_pkg::W;
  localparam int CW = pfa_pkg::CW;

  logic [2:0]   op_q;
  logic [W-1:0] m_q, a_q, b_q;
  logic [W-1:0] rem_q, quo_q, d_q;
  logic [W-1:0] x_q, y_q, acc_q;
  logic [W-1:0] r0_q, r1_q, t0_q, t1_q;
  logic [W-1:0] res_q, out_res_q;
  logic         flag_q, out_flag_q;
  logic [CW-1:0] cnt_q;

  logic [W-1:0] m_eff;
  logic [W:0]   trial;
  logic         trial_ge;
  logic [W-1:0] rem_nx;
  logic [W:0]   dbl_s, addx_s, add_s;
  logic [W-1:0] dbl, addx, acc_nx, qm, nt, alu_res;

  assign m_eff = (modulus_i < W'(2)) ? W'(1) : modulus_i;

  // Divider step: bring in one dividend bit, subtract when it fits
  assign trial    = {rem_q, quo_q[W-1]};
  assign trial_ge = trial >= {1'b0, d_q};
  assign rem_nx   = trial_ge ? W'(trial - {1'b0, d_q}) : trial[W-1:0];

  // Multiplier step: acc = 2*acc (+ x) mod m
  assign dbl_s  = {1'b0, acc_q} + {1'b0, acc_q};
  assign dbl    = (dbl_s >= {1'b0, m_q}) ? W'(dbl_s - {1'b0, m_q}) : dbl_s[W-1:0];
  assign addx_s = {1'b0, dbl} + {1'b0, x_q};
  assign addx   = (addx_s >= {1'b0, m_q}) ? W'(addx_s - {1'b0, m_q}) : addx_s[W-1:0];
  assign acc_nx = y_q[W-1] ? addx : dbl;

  // Quotient reduced mod m, and t0 - q*t1 mod m
  assign qm = (quo_q >= m_q) ? quo_q - m_q : quo_q;
  assign nt = (t0_q >= acc_q) ? t0_q - acc_q : t0_q - acc_q + m_q;

  // Combinational ops: add, subtract, negate
  assign add_s = {1'b0, a_q} + {1'b0, b_q};
  always_comb begin
    case (pfa_pkg::op_e'(op_q))
      pfa_pkg::OP_ADD: alu_res = (add_s >= {1'b0, m_q}) ? W'(add_s - {1'b0, m_q})
                                                          : add_s[W-1:0];
      pfa_pkg::OP_SUB: alu_res = (a_q >= b_q) ? a_q - b_q : a_q - b_q + m_q;
      pfa_pkg::OP_NEG: alu_res = (a_q == '0) ? '0 : m_q - a_q;
      default:         alu_res = '0;
    endcase
  end

  // Step counter shared by divider and multiplier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      case (cmd_i.cmd)
        pfa_pkg::CMD_DIV_STEP,
        pfa_pkg::CMD_MUL_STEP: cnt_q <= cnt_q + CW'(1);
        pfa_pkg::CMD_NONE:     cnt_q <= cnt_q;
        default:               cnt_q <= '0;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.cmd)
      pfa_pkg::CMD_LOAD: begin
        op_q <= op_i;
        a_q  <= a_i;
        b_q  <= b_i;
        m_q  <= m_eff;
      end
      pfa_pkg::CMD_DIV_A: begin
        rem_q <= '0;
        quo_q <= a_q;
        d_q   <= m_q;
      end
      pfa_pkg::CMD_DIV_B: begin
        rem_q <= '0;
        quo_q <= b_q;
        d_q   <= m_q;
      end
      pfa_pkg::CMD_DIV_STEP: begin
        rem_q <= rem_nx;
        quo_q <= {quo_q[W-2:0], trial_ge};
      end
      pfa_pkg::CMD_SET_A: a_q <= rem_q;
      pfa_pkg::CMD_SET_B: b_q <= rem_q;
      pfa_pkg::CMD_ALU: begin
        res_q  <= alu_res;
        flag_q <= 1'b0;
      end
      pfa_pkg::CMD_MUL_AB: begin
        acc_q <= '0;
        x_q   <= a_q;
        y_q   <= b_q;
      end
      pfa_pkg::CMD_MUL_STEP: begin
        acc_q <= acc_nx;
        y_q   <= {y_q[W-2:0], 1'b0};
      end
      pfa_pkg::CMD_SET_MUL: begin
        res_q  <= acc_q;
        flag_q <= 1'b0;
      end
      pfa_pkg::CMD_EINIT: begin
        r0_q <= m_q;
        r1_q <= (pfa_pkg::op_e'(op_q) == pfa_pkg::OP_DIV) ? b_q : a_q;
        t0_q <= '0;
        t1_q <= W'(1);
      end
      pfa_pkg::CMD_EDIV: begin
        rem_q <= '0;
        quo_q <= r0_q;
        d_q   <= r1_q;
      end
      pfa_pkg::CMD_EMUL: begin
        acc_q <= '0;
        x_q   <= t1_q;
        y_q   <= qm;
      end
      pfa_pkg::CMD_EUPD: begin
        r0_q <= r1_q;
        r1_q <= rem_q;
        t0_q <= t1_q;
        t1_q <= nt;
      end
      pfa_pkg::CMD_MUL_AT: begin
        acc_q <= '0;
        x_q   <= a_q;
        y_q   <= t0_q;
      end
      pfa_pkg::CMD_SET_INV: begin
        res_q  <= t0_q;
        flag_q <= 1'b0;
      end
      pfa_pkg::CMD_FLAG: begin
        res_q  <= '0;
        flag_q <= 1'b1;
      end
      pfa_pkg::CMD_PUSH: begin
        out_res_q  <= res_q;
        out_flag_q <= flag_q;
      end
      default: ;
    endcase
  end

  assign status_o.op        = op_q;
  assign status_o.step_last = (cnt_q == CW'(W - 1));
  assign status_o.x_zero    = (pfa_pkg::op_e'(op_q) == pfa_pkg::OP_DIV) ? (b_q == '0)
                                                                         : (a_q == '0);
  assign status_o.r1_zero   = (r1_q == '0);
  assign status_o.r0_one    = (r0_q == W'(1));

  assign result_o       = out_res_q;
  assign zero_divisor_o = out_flag_q;

endmodule

`default_nettype wire

// ===== rtl/core/prime_field_alu.sv =====
// Prime field ALU: one item at a time. Both operands are reduced first (shift-subtract
// divider). Add, subtract, negate: one ALU step, and the next item is taken once the
// result is pushed; multiply adds one double-and-add step per operand bit. Invert adds a
// divider pass then a multiplier pass per Euclid iteration, up to about 47 iterations;
// divide adds one more multiply.
// A finished result waits in the output register; the next item is taken meanwhile.
// Reset (rst_ni low, async) idles the sequencer, empties the output, sets the modulus.
`default_nettype none

module prime_field_alu (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire [pfa_pkg::W-1:0]  cfg_wdata_i,
  pfa_in_if.sink                in_i,
  pfa_out_if.source             out_o
);

  logic [pfa_pkg::W-1:0] modulus_q;
  pfa_pkg::dp_cmd_t      cmd;
  pfa_pkg::dp_status_t   status;

  // Modulus register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= pfa_pkg::MOD_RESET;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  pfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pfa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (in_i.op),
    .a_i            (in_i.operand_a),
    .b_i            (in_i.operand_b),
    .modulus_i      (modulus_q),
    .status_o       (status),
    .result_o       (out_o.result),
    .zero_divisor_o (out_o.zero_divisor)
  );

`ifndef ASSERT_OFF
  // Results always reduced below the effective modulus
  a_res_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((modulus_q < pfa_pkg::W'(2)) ? (out_o.result == '0)
                                                   : (out_o.result < modulus_q)))
    else $error("result not reduced");

  // Zero divisor case always returns zero
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.zero_divisor) |-> (out_o.result == '0))
    else $error("flagged result not zero");

  // Busy after an input transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while busy");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for prime_field_alu: predicts each result from a software
// model of the field arithmetic and compares every transfer. Depends on pfa_pkg and
// the pfa_in_if / pfa_out_if interfaces.
`timescale 1ns / 1ps

module tb_top;

  localparam int W = pfa_pkg::W;

  // Opcodes with no operation behind them
  localparam logic [2:0] OP_RSVD_LO = 3'd6;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [W-1:0] cfg_wdata_i = '0;

  pfa_in_if  alu_in ();
  pfa_out_if alu_out ();

  prime_field_alu uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (alu_in.sink),
    .out_o       (alu_out.source)
  );

  typedef struct packed {
    logic [W-1:0] value;
    logic         zdiv;
  } field_res_t;

  // Expected results, oldest first
  field_res_t   exp_mem [16];
  logic [3:0]   exp_wr = '0;
  logic [3:0]   exp_rd = '0;
  int           exp_cnt = 0;

  logic [W-1:0] field_mod;
  int           n_errors = 0;
  int           n_results = 0;
  int           n_sent = 0;
  int           n_zdiv = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end

  // ---------------- field arithmetic predictor ----------------
  function automatic logic [63:0] mod_add(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [64:0] s;
    s = x + y;
    if (s >= m) s = s - m;
    return s[63:0];
  endfunction

  function automatic logic [63:0] mod_sub(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    return (x >= y) ? x - y : x - y + m;
  endfunction

  function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [127:0] p;
    p = x * y;
    return 64'(p % m);
  endfunction

  // Extended Euclid; returns 1 and the inverse when x is a unit mod m
  function automatic logic mod_inv(logic [63:0] x, logic [63:0] m, output logic [63:0] inv);
    logic [63:0] r0, r1, t0, t1, q, nr, nt;
    r0 = m; r1 = x; t0 = 0; t1 = (m == 1) ? 0 : 1;
    inv = 0;
    if (x == 0) return 1'b0;
    while (r1 != 0) begin
      q  = r0 / r1;
      nr = r0 - q * r1;
      nt = mod_sub(t0, mod_mul(q % m, t1, m), m);
      r0 = r1; r1 = nr; t0 = t1; t1 = nt;
    end
    if (r0 != 1) return 1'b0;
    inv = t0;
    return 1'b1;
  endfunction

  function automatic field_res_t field_predict(logic [2:0] op, logic [W-1:0] ra,
                                               logic [W-1:0] rb);
    logic [63:0] m, a, b, iv;
    field_res_t  r;
    m = (field_mod < 2) ? 64'd1 : 64'(field_mod);
    a = 64'(ra) % m;
    b = 64'(rb) % m;
    r = '0;
    case (op)
      pfa_pkg::OP_ADD: r.value = W'(mod_add(a, b, m));
      pfa_pkg::OP_SUB: r.value = W'(mod_sub(a, b, m));
      pfa_pkg::OP_MUL: r.value = W'(mod_mul(a, b, m));
      pfa_pkg::OP_DIV: begin
        if (mod_inv(b, m, iv)) r.value = W'(mod_mul(a, iv, m));
        else r.zdiv = 1'b1;
      end
      pfa_pkg::OP_NEG: r.value = (a == 0) ? '0 : W'(m - a);
      pfa_pkg::OP_INV: begin
        if (mod_inv(a, m, iv)) r.value = W'(iv);
        else r.zdiv = 1'b1;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // ---------------- expected result store ----------------
  task automatic exp_store(field_res_t r);
    exp_mem[exp_wr] = r;
    exp_wr = exp_wr + 4'd1;
    exp_cnt++;
  endtask

  task automatic exp_take(output field_res_t r);
    r = exp_mem[exp_rd];
    exp_rd = exp_rd + 4'd1;
    exp_cnt--;
  endtask

  // ---------------- driving ----------------
  task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
    n_errors++;
    $display("[%0t] mismatch %s: got 0x%08h want 0x%08h", $realtime, what, got, want);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) @(posedge clk_i);
  endtask

  // Send one operation; random hold-off before raising valid
  task automatic send_op(logic [2:0] op, logic [W-1:0] a, logic [W-1:0] b, bit gaps = 1);
    int n;
    n = gaps ? $urandom_range(0, 15) : 0;
    if (n > 0) begin
      alu_in.valid <= 1'b0;
      idle_cycles(n);
    end
    alu_in.valid     <= 1'b1;
    alu_in.op        <= op;
    alu_in.operand_a <= a;
    alu_in.operand_b <= b;
    exp_store(field_predict(op, a, b));
    do @(posedge clk_i); while (!alu_in.ready);
    n_sent++;
  endtask

  // Drop valid, drain, let the sequencer settle, then write the modulus
  task automatic write_modulus(logic [W-1:0] m);
    alu_in.valid <= 1'b0;
    while (exp_cnt != 0) @(posedge clk_i);
    idle_cycles(10);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    field_mod = m;
  endtask

  // ---------------- result checking ----------------
  initial begin
    alu_out.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      int n;
      field_res_t want;
      n = $urandom_range(0, 15);
      if (n > 0) begin
        alu_out.ready <= 1'b0;
        idle_cycles(n);
      end
      alu_out.ready <= 1'b1;
      do @(posedge clk_i); while (!alu_out.valid);
      if (exp_cnt == 0) begin
        report_mismatch("unexpected result", alu_out.result, '0);
      end else begin
        exp_take(want);
        if (alu_out.result !== want.value)
          report_mismatch("result", alu_out.result, want.value);
        if (alu_out.zero_divisor !== want.zdiv)
          report_mismatch("zero_divisor", W'(alu_out.zero_divisor), W'(want.zdiv));
        n_results++;
        if (want.zdiv) n_zdiv++;
      end
    end
  end

  // ---------------- tests ----------------
  function automatic logic [W-1:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return field_mod - 1;
      2: return field_mod;
      3: return '1;
      4: return W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_op(pfa_pkg::OP_ADD, '0, '0);
    send_op(pfa_pkg::OP_ADD, field_mod - 1, field_mod - 1);
    send_op(pfa_pkg::OP_ADD, '1, '1);
    send_op(pfa_pkg::OP_SUB, '0, 32'd1);
    send_op(pfa_pkg::OP_SUB, 32'h5555_5555, 32'hAAAA_AAAA);
    send_op(pfa_pkg::OP_MUL, field_mod - 1, field_mod - 1);
    send_op(pfa_pkg::OP_MUL, '1, 32'h1234_5678);
    send_op(pfa_pkg::OP_DIV, 32'd7, '0);
    send_op(pfa_pkg::OP_DIV, 32'd7, field_mod);
    send_op(pfa_pkg::OP_DIV, 32'hDEAD_BEEF, 32'd3);
    send_op(pfa_pkg::OP_NEG, '0, '1);
    send_op(pfa_pkg::OP_NEG, field_mod, '0);
    send_op(pfa_pkg::OP_NEG, 32'd1, '0);
    send_op(pfa_pkg::OP_INV, '0, '0);
    send_op(pfa_pkg::OP_INV, 32'd1, '0);
    send_op(pfa_pkg::OP_INV, field_mod - 1, '0);
    send_op(OP_RSVD_LO, '1, '1);
    send_op(OP_RSVD_HI, 32'd5, 32'd9);
  endtask

  task automatic test_random(int n);
    repeat (n) begin
      logic [2:0] op;
      if ($urandom_range(0, 19) == 0)
        op = $urandom_range(0, 1) ? OP_RSVD_HI : OP_RSVD_LO;
      else
        op = 3'($urandom_range(int'(pfa_pkg::OP_ADD), int'(pfa_pkg::OP_INV)));
      // Some bursts with no gaps at all
      send_op(op, rand_operand(), rand_operand(), $urandom_range(0, 4) != 0);
    end
  endtask

  task automatic test_modulus(logic [W-1:0] m, int n);
    write_modulus(m);
    send_op(pfa_pkg::OP_INV, 32'd2, '0);
    send_op(pfa_pkg::OP_DIV, '1, 32'd6);
    test_random(n);
  endtask

  initial begin
    alu_in.valid     <= 1'b0;
    alu_in.op        <= pfa_pkg::OP_ADD;
    alu_in.operand_a <= '0;
    alu_in.operand_b <= '0;
    field_mod        = pfa_pkg::MOD_RESET;
    idle_cycles(3);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(500);
    test_modulus(32'hFFFF_FFFF, 100);  // largest, composite
    test_modulus(32'd2, 60);            // smallest prime
    test_modulus(32'd0, 30);            // degenerate: treated as one
    test_modulus(32'd1, 30);
    test_modulus(32'd65537, 120);
    test_modulus(32'd1000, 60);         // composite, many non-units
    test_modulus(32'h7FFF_FFFF, 150);
    test_modulus(32'h8000_0000, 40);
    test_modulus(pfa_pkg::MOD_RESET, 120);

    alu_in.valid <= 1'b0;
    while (exp_cnt != 0) @(posedge clk_i);
    idle_cycles(200);
    $display("Ran %0d operations across 10 modulus settings with random stalls on both sides.",
             n_sent);
    $display("Checked %0d results, %0d of them with the zero divisor flag.",
             n_results, n_zdiv);
    if (n_errors == 0 && exp_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
